// ===== src/tfn_pkg.sv =====
package tfn_pkg;

   // Coordinate and result widths.
   localparam int COORD_W = 24;
   localparam int FRAC_W = 14;
   localparam int OUT_W = 16;

   // Derived arithmetic widths.
   localparam int EDGE_W = COORD_W + 1;
   localparam int PROD_W = 2 * EDGE_W;
   localparam int CROSS_W = 2 * EDGE_W;
   localparam int MAG_W = CROSS_W - 1;
   localparam int LO_W = MAG_W / 2;
   localparam int HI_W = MAG_W - LO_W;
   localparam int SQ_W = 2 * MAG_W;
   localparam int SUM_W = SQ_W + 2;
   localparam int T_W = FRAC_W + 1;
   localparam int RES_W = SUM_W + 2 * FRAC_W + 5;
   localparam int M_SHIFT = 2 * FRAC_W + 2;

   // Nine vertex coordinates: v0 x,y,z then v1 then v2.
   typedef struct packed {
      logic [8:0][COORD_W-1:0] coord;
   } vert_type;

   // Cross product split into sign and magnitude.
   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic                  degen;
   } cross_type;

   // State of the rounding search for all three components.
   typedef struct packed {
      logic [SUM_W-1:0]      sum;
      logic [2:0][RES_W-1:0] res;
      logic [2:0][RES_W-1:0] odd;
      logic [2:0][T_W-1:0]   quo;
      logic [2:0]            neg;
      logic                  degen;
   } search_type;

   // One result.
   typedef struct packed {
      logic [2:0][OUT_W-1:0] normal;
      logic                  degen;
   } result_type;

endpackage

// ===== src/tfn_cross.sv =====
module tfn_cross (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tfn_pkg::vert_type     in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tfn_pkg::cross_type    out_data
);

   localparam int NSTG = 3;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] en;

   logic [1:0][2:0][tfn_pkg::EDGE_W-1:0] dif_ff, dif_in;
   logic [5:0][tfn_pkg::PROD_W-1:0]      prod_ff, prod_in;
   tfn_pkg::cross_type                   cross_ff, cross_in;

   // A stage takes new data when it is empty or its successor takes its data.
   assign en[2] = !vld_ff[2] || out_ready;
   assign en[1] = !vld_ff[1] || en[2];
   assign en[0] = !vld_ff[0] || en[1];

   assign in_ready  = en[0];
   assign out_valid = vld_ff[2];
   assign out_data  = cross_ff;

   // Edges v0 - v1 and v0 - v2, one bit wider than the coordinates.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dif_in[0][j] = {in_data.coord[j][tfn_pkg::COORD_W-1], in_data.coord[j]}
                      - {in_data.coord[3+j][tfn_pkg::COORD_W-1], in_data.coord[3+j]};
         dif_in[1][j] = {in_data.coord[j][tfn_pkg::COORD_W-1], in_data.coord[j]}
                      - {in_data.coord[6+j][tfn_pkg::COORD_W-1], in_data.coord[6+j]};
      end
   end

   // The six signed products of the cross product.
   always_comb begin
      prod_in[0] = $signed(dif_ff[0][1]) * $signed(dif_ff[1][2]);
      prod_in[1] = $signed(dif_ff[0][2]) * $signed(dif_ff[1][1]);
      prod_in[2] = $signed(dif_ff[0][2]) * $signed(dif_ff[1][0]);
      prod_in[3] = $signed(dif_ff[0][0]) * $signed(dif_ff[1][2]);
      prod_in[4] = $signed(dif_ff[0][0]) * $signed(dif_ff[1][1]);
      prod_in[5] = $signed(dif_ff[0][1]) * $signed(dif_ff[1][0]);
   end

   // Cross components, their signs and magnitudes, and the zero test.
   always_comb begin
      logic [tfn_pkg::CROSS_W-1:0] comp;
      logic [tfn_pkg::CROSS_W-1:0] absv;
      cross_in.degen = 1'b1;
      for (int j = 0; j < 3; j++) begin
         comp = prod_ff[2*j] - prod_ff[2*j+1];
         absv = comp[tfn_pkg::CROSS_W-1] ? (~comp + 1'b1) : comp;
         cross_in.neg[j] = comp[tfn_pkg::CROSS_W-1];
         cross_in.mag[j] = absv[tfn_pkg::MAG_W-1:0];
         if (comp != '0) begin
            cross_in.degen = 1'b0;
         end
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         if (en[1]) vld_ff[1] <= vld_ff[0];
         if (en[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en[0]) dif_ff   <= dif_in;
      if (en[1]) prod_ff  <= prod_in;
      if (en[2]) cross_ff <= cross_in;
   end

endmodule

// ===== src/tfn_norm.sv =====
module tfn_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tfn_pkg::cross_type    in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tfn_pkg::search_type   out_data
);

   localparam int NSTG = 4;
   localparam int LO = tfn_pkg::LO_W;
   localparam int HI = tfn_pkg::HI_W;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] en;

   logic [2:0][2*HI-1:0]            hh_ff, hh_in;
   logic [2:0][HI+LO-1:0]           hl_ff, hl_in;
   logic [2:0][2*LO-1:0]            ll_ff, ll_in;
   logic [2:0][tfn_pkg::SQ_W-1:0]   sq_ff, sq_in, sqb_ff;
   logic [tfn_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [2:0]                      neg_ff1, neg_ff2, neg_ff3;
   logic                            deg_ff1, deg_ff2, deg_ff3;
   tfn_pkg::search_type             srch_ff, srch_in;

   assign en[3] = !vld_ff[3] || out_ready;
   assign en[2] = !vld_ff[2] || en[3];
   assign en[1] = !vld_ff[1] || en[2];
   assign en[0] = !vld_ff[0] || en[1];

   assign in_ready  = en[0];
   assign out_valid = vld_ff[3];
   assign out_data  = srch_ff;

   // Partial products of each square, split into high and low halves.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         hh_in[j] = in_data.mag[j][tfn_pkg::MAG_W-1:LO] * in_data.mag[j][tfn_pkg::MAG_W-1:LO];
         hl_in[j] = in_data.mag[j][tfn_pkg::MAG_W-1:LO] * in_data.mag[j][LO-1:0];
         ll_in[j] = in_data.mag[j][LO-1:0] * in_data.mag[j][LO-1:0];
      end
   end

   // Squares of the three magnitudes.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sq_in[j] = (tfn_pkg::SQ_W'(hh_ff[j]) << (2 * LO))
                  + (tfn_pkg::SQ_W'(hl_ff[j]) << (LO + 1))
                  + tfn_pkg::SQ_W'(ll_ff[j]);
      end
   end

   // Squared length of the cross product.
   assign sum_in = tfn_pkg::SUM_W'(sq_ff[0]) + tfn_pkg::SUM_W'(sq_ff[1])
                 + tfn_pkg::SUM_W'(sq_ff[2]);

   // Start of the search: quotient zero, residue M - S, odd term -S.
   always_comb begin
      srch_in.sum   = sum_ff;
      srch_in.neg   = neg_ff3;
      srch_in.degen = deg_ff3;
      for (int j = 0; j < 3; j++) begin
         srch_in.res[j] = (tfn_pkg::RES_W'(sqb_ff[j]) << tfn_pkg::M_SHIFT)
                        - tfn_pkg::RES_W'(sum_ff);
         srch_in.odd[j] = '0 - tfn_pkg::RES_W'(sum_ff);
         srch_in.quo[j] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         if (en[1]) vld_ff[1] <= vld_ff[0];
         if (en[2]) vld_ff[2] <= vld_ff[1];
         if (en[3]) vld_ff[3] <= vld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         ll_ff   <= ll_in;
         neg_ff1 <= in_data.neg;
         deg_ff1 <= in_data.degen;
      end
      if (en[1]) begin
         sq_ff   <= sq_in;
         neg_ff2 <= neg_ff1;
         deg_ff2 <= deg_ff1;
      end
      if (en[2]) begin
         sum_ff  <= sum_in;
         sqb_ff  <= sq_ff;
         neg_ff3 <= neg_ff2;
         deg_ff3 <= deg_ff2;
      end
      if (en[3]) begin
         srch_ff <= srch_in;
      end
   end

endmodule

// ===== src/tfn_search.sv =====
module tfn_search (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tfn_pkg::search_type   in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tfn_pkg::result_type   out_data
);

   localparam int NBIT = tfn_pkg::T_W;
   localparam int NSTG = NBIT + 1;

   logic [NSTG-1:0]     vld_ff;
   logic [NSTG-1:0]     en;
   tfn_pkg::search_type st_ff [NBIT];
   tfn_pkg::result_type out_ff, out_in;

   assign en[NSTG-1] = !vld_ff[NSTG-1] || out_ready;
   assign in_ready   = en[0];
   assign out_valid  = vld_ff[NSTG-1];
   assign out_data   = out_ff;

   // One quotient bit per stage, most significant first. Trying bit K adds
   // D = 2^(K+2)*P + 2^(2K+2)*S to the odd square; it is kept when D fits
   // in the residue R.
   for (genvar i = 0; i < NBIT; i++) begin : g_bit
      localparam int K = tfn_pkg::FRAC_W - i;
      tfn_pkg::search_type cur, nxt;

      if (i == 0) begin : g_first
         assign cur = in_data;
      end else begin : g_next
         assign cur = st_ff[i-1];
      end

      assign en[i] = !vld_ff[i] || en[i+1];

      always_comb begin
         logic signed [tfn_pkg::RES_W-1:0] ps;
         logic signed [tfn_pkg::RES_W-1:0] sw;
         logic signed [tfn_pkg::RES_W-1:0] rs;
         logic signed [tfn_pkg::RES_W-1:0] dd;
         nxt = cur;
         sw  = tfn_pkg::RES_W'(cur.sum);
         for (int j = 0; j < 3; j++) begin
            ps = cur.odd[j];
            rs = cur.res[j];
            dd = (ps <<< (K + 2)) + (sw <<< (2 * K + 2));
            if (dd <= rs) begin
               nxt.res[j]    = rs - dd;
               nxt.odd[j]    = ps + (sw <<< (K + 1));
               nxt.quo[j][K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[i]) begin
            st_ff[i] <= nxt;
         end
      end
   end

   // Valid bits of the bit stages and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         for (int i = 1; i < NSTG; i++) begin
            if (en[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Apply the signs; a degenerate triangle gives a zero normal.
   always_comb begin
      out_in.degen = st_ff[NBIT-1].degen;
      for (int j = 0; j < 3; j++) begin
         if (st_ff[NBIT-1].degen) begin
            out_in.normal[j] = '0;
         end else if (st_ff[NBIT-1].neg[j]) begin
            out_in.normal[j] = '0 - tfn_pkg::OUT_W'(st_ff[NBIT-1].quo[j]);
         end else begin
            out_in.normal[j] = tfn_pkg::OUT_W'(st_ff[NBIT-1].quo[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NSTG-1]) begin
         out_ff <= out_in;
      end
   end

endmodule

// ===== src/triangle_face_normal.sv =====
// Triangle face normal.
// A request carries the three vertices of a triangle on req_v0_* .. req_v2_*
// as signed 24-bit coordinates and is taken when req_valid and req_ready are
// both high. The response gives the unit normal of the cross product of the
// edges v0-v1 and v0-v2, each component scaled by 16384 and rounded to
// nearest (ties away from zero), on rsp_normal_*; it is taken when rsp_valid
// and rsp_ready are both high. A triangle whose cross product is zero gives
// a zero normal with rsp_degenerate set.
// The block is a pipeline of 23 register stages: three for the edges and the
// cross product, four for the squares and the squared length, fifteen for
// the rounded quotient (one bit per stage, shared by all three components)
// and the output register. One request is accepted every cycle unless a
// stalled receiver has filled the pipeline.
// Each stage holds its data while its successor is full and stalled, so a
// stalled receiver fills the empty stages first and only then lowers
// req_ready; nothing is lost or repeated. Reset clears all valid bits.
module triangle_face_normal (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tfn_pkg::COORD_W-1:0] req_v0_x,
   input  logic [tfn_pkg::COORD_W-1:0] req_v0_y,
   input  logic [tfn_pkg::COORD_W-1:0] req_v0_z,
   input  logic [tfn_pkg::COORD_W-1:0] req_v1_x,
   input  logic [tfn_pkg::COORD_W-1:0] req_v1_y,
   input  logic [tfn_pkg::COORD_W-1:0] req_v1_z,
   input  logic [tfn_pkg::COORD_W-1:0] req_v2_x,
   input  logic [tfn_pkg::COORD_W-1:0] req_v2_y,
   input  logic [tfn_pkg::COORD_W-1:0] req_v2_z,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tfn_pkg::OUT_W-1:0]   rsp_normal_x,
   output logic [tfn_pkg::OUT_W-1:0]   rsp_normal_y,
   output logic [tfn_pkg::OUT_W-1:0]   rsp_normal_z,
   output logic                        rsp_degenerate
);

   tfn_pkg::vert_type   vert;
   tfn_pkg::cross_type  cross_d;
   tfn_pkg::search_type srch_d;
   tfn_pkg::result_type res_d;
   logic                cross_vld, cross_rdy;
   logic                srch_vld, srch_rdy;

   // Gather the request into one bundle.
   assign vert.coord[0] = req_v0_x;
   assign vert.coord[1] = req_v0_y;
   assign vert.coord[2] = req_v0_z;
   assign vert.coord[3] = req_v1_x;
   assign vert.coord[4] = req_v1_y;
   assign vert.coord[5] = req_v1_z;
   assign vert.coord[6] = req_v2_x;
   assign vert.coord[7] = req_v2_y;
   assign vert.coord[8] = req_v2_z;

   tfn_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (vert),
      .out_valid (cross_vld),
      .out_ready (cross_rdy),
      .out_data  (cross_d)
   );

   tfn_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cross_vld),
      .in_ready  (cross_rdy),
      .in_data   (cross_d),
      .out_valid (srch_vld),
      .out_ready (srch_rdy),
      .out_data  (srch_d)
   );

   tfn_search u_search (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (srch_vld),
      .in_ready  (srch_rdy),
      .in_data   (srch_d),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (res_d)
   );

   assign rsp_normal_x   = res_d.normal[0];
   assign rsp_normal_y   = res_d.normal[1];
   assign rsp_normal_z   = res_d.normal[2];
   assign rsp_degenerate = res_d.degen;

   // A degenerate triangle gives a zero normal.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate response with a nonzero normal");

   // A proper triangle has at least one large component, so never all zero.
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0)
      else $error("zero normal for a proper triangle");

   // Every component lies within one unit of length.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         $signed(rsp_normal_x) >= -16384 && $signed(rsp_normal_x) <= 16384 &&
         $signed(rsp_normal_y) >= -16384 && $signed(rsp_normal_y) <= 16384 &&
         $signed(rsp_normal_z) >= -16384 && $signed(rsp_normal_z) <= 16384)
      else $error("normal component out of range");

endmodule
